@@ rtl/dssm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the dual stack shared memory unit.
package dssm_pkg;

  localparam int DEPTH     = 256;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 9;
  localparam int OUT_CNT_W = 9;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CMP_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int CAP_RESET = (DEPTH < 256) ? DEPTH : 256;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FIRST  = 2'd0,
    CMD_PUSH_SECOND = 2'd1,
    CMD_POP_FIRST   = 2'd2,
    CMD_POP_SECOND  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming beat
    logic exec;   // apply push or pop, write memory
    logic rd;     // read both tops
    logic resp;   // result is on the output ports
  } ctl_t;

endpackage

@@ rtl/dssm_ram.sv @@
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
module dssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/dssm_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine that sequences one command through the datapath.
module dssm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output dssm_pkg::ctl_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
          busy_nxt  = 1'b1;
        end
      end
      S_EXEC: state_nxt = S_READ;
      S_READ: state_nxt = S_RESP;
      S_RESP: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy     = busy_r;
  assign ctl.load = start && !busy_r;
  assign ctl.exec = (state_r == S_EXEC);
  assign ctl.rd   = (state_r == S_READ);
  assign ctl.resp = (state_r == S_RESP);

endmodule

@@ rtl/dssm_dpath.sv @@
`timescale 1ns / 1ps
// Datapath: capacity register, stack depths, shared memory and result fields.
module dssm_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dssm_pkg::ctl_t                      ctl,
  input  logic [dssm_pkg::CMD_W-1:0]          in_command,
  input  logic signed [dssm_pkg::DATA_W-1:0]  in_value,
  input  logic                                cfg_we,
  input  logic [dssm_pkg::CFG_W-1:0]          cfg_capacity,
  output logic [dssm_pkg::STAT_W-1:0]         out_status,
  output logic signed [dssm_pkg::DATA_W-1:0]  out_top_first,
  output logic signed [dssm_pkg::DATA_W-1:0]  out_top_second,
  output logic                                out_first_empty,
  output logic                                out_second_empty,
  output logic [dssm_pkg::OUT_CNT_W-1:0]      out_first_count,
  output logic [dssm_pkg::OUT_CNT_W-1:0]      out_second_count
);

  dssm_pkg::cmd_t                   cmd_r;
  logic [dssm_pkg::DATA_W-1:0]      value_r;
  logic [dssm_pkg::CNT_W-1:0]       cap_r, cap_nxt;
  logic [dssm_pkg::CNT_W-1:0]       d1_r, d1_nxt;
  logic [dssm_pkg::CNT_W-1:0]       d2_r, d2_nxt;
  dssm_pkg::status_t                status_r, status_nxt;

  logic [dssm_pkg::CMP_W-1:0]       cfg_ext;
  logic [dssm_pkg::CNT_W:0]         used;
  logic                             full;
  logic                             we;
  logic [dssm_pkg::ADDR_W-1:0]      waddr;
  logic [dssm_pkg::ADDR_W-1:0]      raddr_a, raddr_b;
  logic [dssm_pkg::DATA_W-1:0]      rdata_a, rdata_b;

  // Out-of-range capacities are clamped once, at write time.
  always_comb begin
    cfg_ext = dssm_pkg::CMP_W'(cfg_capacity);
    if (cfg_ext == '0) begin
      cap_nxt = dssm_pkg::CNT_W'(1);
    end else if (cfg_ext > dssm_pkg::CMP_W'(dssm_pkg::DEPTH)) begin
      cap_nxt = dssm_pkg::CNT_W'(dssm_pkg::DEPTH);
    end else begin
      cap_nxt = dssm_pkg::CNT_W'(cfg_ext);
    end
  end

  assign used = {1'b0, d1_r} + {1'b0, d2_r};
  assign full = (used >= {1'b0, cap_r});

  always_comb begin
    d1_nxt     = d1_r;
    d2_nxt     = d2_r;
    status_nxt = dssm_pkg::ST_DONE;
    we         = 1'b0;
    waddr      = dssm_pkg::ADDR_W'(d1_r);
    case (cmd_r)
      dssm_pkg::CMD_PUSH_FIRST: begin
        if (full) begin
          status_nxt = dssm_pkg::ST_FULL;
        end else begin
          we     = 1'b1;
          d1_nxt = d1_r + dssm_pkg::CNT_W'(1);
        end
      end
      dssm_pkg::CMD_PUSH_SECOND: begin
        waddr = dssm_pkg::ADDR_W'(cap_r - dssm_pkg::CNT_W'(1) - d2_r);
        if (full) begin
          status_nxt = dssm_pkg::ST_FULL;
        end else begin
          we     = 1'b1;
          d2_nxt = d2_r + dssm_pkg::CNT_W'(1);
        end
      end
      dssm_pkg::CMD_POP_FIRST: begin
        if (d1_r == '0) begin
          status_nxt = dssm_pkg::ST_EMPTY;
        end else begin
          d1_nxt = d1_r - dssm_pkg::CNT_W'(1);
        end
      end
      dssm_pkg::CMD_POP_SECOND: begin
        if (d2_r == '0) begin
          status_nxt = dssm_pkg::ST_EMPTY;
        end else begin
          d2_nxt = d2_r - dssm_pkg::CNT_W'(1);
        end
      end
      default: status_nxt = dssm_pkg::ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= dssm_pkg::cmd_t'(in_command);
      value_r <= in_value;
    end
    if (ctl.exec) begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= dssm_pkg::CNT_W'(dssm_pkg::CAP_RESET);
      d1_r  <= '0;
      d2_r  <= '0;
    end else if (cfg_we) begin
      // A new capacity empties both stacks.
      cap_r <= cap_nxt;
      d1_r  <= '0;
      d2_r  <= '0;
    end else if (ctl.exec) begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
    end
  end

  // Tops are read after the depths have settled; empty stacks read junk that is masked.
  assign raddr_a = dssm_pkg::ADDR_W'(d1_r - dssm_pkg::CNT_W'(1));
  assign raddr_b = dssm_pkg::ADDR_W'(cap_r - d2_r);

  dssm_ram #(
    .WIDTH (dssm_pkg::DATA_W),
    .DEPTH (dssm_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ctl.exec && we),
    .waddr   (waddr),
    .wdata   (value_r),
    .re      (ctl.rd),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign out_status       = status_r;
  assign out_first_empty  = (d1_r == '0);
  assign out_second_empty = (d2_r == '0);
  assign out_top_first    = out_first_empty  ? '0 : $signed(rdata_a);
  assign out_top_second   = out_second_empty ? '0 : $signed(rdata_b);
  assign out_first_count  = dssm_pkg::OUT_CNT_W'(d1_r);
  assign out_second_count = dssm_pkg::OUT_CNT_W'(d2_r);

endmodule

@@ rtl/dual_stack_shared_memory_unit.sv @@
`timescale 1ns / 1ps
// Top level of the dual stack shared memory unit.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-------------------------------
//  input   | in_command, in_value                   | start && !busy
//  result  | out_status, out_top_*, out_*_empty/cnt | out_strobe, one cycle, no stall
//  config  | cfg_capacity                           | cfg_valid && cfg_ready
//
// After the accept edge each command runs through S_EXEC (update and memory write),
// S_READ (both tops read through the two read ports) and S_RESP (the result beat).
// busy stays high from the accept edge until the result beat has been shown, so the
// next command is accepted in the cycle after the result beat at the earliest.
// Reset is synchronous: both stacks empty, capacity 256 (or DEPTH if smaller).
// The memory needs no clearing pass; reads of an empty stack are masked to zero.
module dual_stack_shared_memory_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [dssm_pkg::CMD_W-1:0]          in_command,
  input  logic signed [dssm_pkg::DATA_W-1:0]  in_value,
  output logic                                out_strobe,
  output logic [dssm_pkg::STAT_W-1:0]         out_status,
  output logic signed [dssm_pkg::DATA_W-1:0]  out_top_first,
  output logic signed [dssm_pkg::DATA_W-1:0]  out_top_second,
  output logic                                out_first_empty,
  output logic                                out_second_empty,
  output logic [dssm_pkg::OUT_CNT_W-1:0]      out_first_count,
  output logic [dssm_pkg::OUT_CNT_W-1:0]      out_second_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dssm_pkg::CFG_W-1:0]          cfg_capacity
);

  dssm_pkg::ctl_t ctl;

  dssm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  assign cfg_ready  = !busy;
  assign out_strobe = ctl.resp;

  dssm_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .in_command       (in_command),
    .in_value         (in_value),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_capacity     (cfg_capacity),
    .out_status       (out_status),
    .out_top_first    (out_top_first),
    .out_top_second   (out_top_second),
    .out_first_empty  (out_first_empty),
    .out_second_empty (out_second_empty),
    .out_first_count  (out_first_count),
    .out_second_count (out_second_count)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result beat outside a busy period");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_strobe))
    else $error("accepted command did not raise busy");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_first_empty) |-> (out_top_first == '0 && out_first_count == '0))
    else $error("empty first stack reports a top word or count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (({1'b0, out_first_count} + {1'b0, out_second_count})
                    <= (dssm_pkg::OUT_CNT_W + 1)'(dssm_pkg::DEPTH)))
    else $error("combined stack counts exceed memory depth");

endmodule
